@@ sv/hclb_pkg.sv @@
package hclb_pkg;

   localparam int MAX_SYMBOLS = 512;
   localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS;
   localparam int SYM_W       = $clog2(MAX_SYMBOLS);
   localparam int NODE_W      = $clog2(NODE_SLOTS);
   localparam int CNT_W       = SYM_W + 1;
   localparam int FREQ_W      = 32;
   localparam int WEIGHT_W    = FREQ_W + SYM_W;
   localparam int LEN_W       = 8;
   localparam int LIM_W       = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = CNT_W;

   localparam logic [LEN_W-1:0]     LEN_CLAMP           = 8'd255;
   localparam logic [CNT_W-1:0]     SYMBOL_COUNT_RESET  = 10'd256;
   localparam logic [LIM_W-1:0]     MAX_LEN_RESET       = 5'd15;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE_LENGTH = 1'b1;
   localparam logic                 MODE_LOAD           = 1'b0;
   localparam logic                 MODE_READ           = 1'b1;
   localparam logic                 KIND_BUILD          = 1'b0;
   localparam logic                 KIND_READ           = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_CLEAR = 4'd1,
      OP_LEAF  = 4'd2,
      OP_SCAN  = 4'd3,
      OP_MERGE = 4'd4,
      OP_WSYM  = 4'd5,
      OP_WLEAF = 4'd6,
      OP_WUP   = 4'd7,
      OP_FSCAN = 4'd8,
      OP_FWR   = 4'd9
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rst_idx;
      logic   rst_srch;
      logic   load_wr;
      logic   rd_issue;
      logic   out_load;
      logic   out_kind;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_done;
      logic used_zero;
      logic used_one;
      logic more_merge;
      logic step_done;
      logic sym_end;
      logic leaf_valid;
      logic node_hp;
      logic hi_found;
      logic out_free;
   } stat_type;

endpackage

@@ sv/hclb_if.sv @@
interface hclb_req_if import hclb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [SYM_W-1:0]  symbol;
   logic [FREQ_W-1:0] frequency;
   logic              last;

   modport source (output valid, mode, symbol, frequency, last, input ready);
   modport sink   (input valid, mode, symbol, frequency, last, output ready);
endinterface

interface hclb_rsp_if import hclb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [LEN_W-1:0] code_length;
   logic [CNT_W-1:0] used_count;

   modport source (output valid, kind, code_length, used_count, input ready);
   modport sink   (input valid, kind, code_length, used_count, output ready);
endinterface

@@ sv/huffman_code_length_builder.sv @@
// Builds length-limited Huffman code lengths for up to 512 symbols. A load request
// writes one frequency; a load marked last starts a build and is answered by a
// build-finished reply. A read request returns the stored length and the used
// count: the length is read into a register and then loaded into the output
// register once that is free. The build is sequential over one single-port node
// memory: a clear of all 512 entries of the length store, a pass that creates the
// leaves, then for every merge a scan of all nodes created so far and three writes,
// a depth walk over the symbols, and a fixup pass for each length adjustment.
// After reset all 512 entries of the length store are cleared before the first
// request is accepted; configuration writes are taken throughout.
module huffman_code_length_builder import hclb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   hclb_req_if.sink              req_if,
   hclb_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   hclb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hclb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_symbol      (req_if.symbol),
      .req_frequency   (req_if.frequency),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_kind        (rsp_if.kind),
      .rsp_code_length (rsp_if.code_length),
      .rsp_used_count  (rsp_if.used_count)
   );

endmodule

@@ sv/hclb_ctrl.sv @@
module hclb_ctrl import hclb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_mode,
   input  logic     req_last,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [11:0] {
      S_INIT  = 12'b0000_0000_0001,
      S_IDLE  = 12'b0000_0000_0010,
      S_REPLY = 12'b0000_0000_0100,
      S_CLEAR = 12'b0000_0000_1000,
      S_LEAF  = 12'b0000_0001_0000,
      S_SCAN  = 12'b0000_0010_0000,
      S_MERGE = 12'b0000_0100_0000,
      S_WSYM  = 12'b0000_1000_0000,
      S_WLEAF = 12'b0001_0000_0000,
      S_WUP   = 12'b0010_0000_0000,
      S_FSCAN = 12'b0100_0000_0000,
      S_FWR   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) begin
               cmd.rst_idx = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_READ) begin
                  cmd.rd_issue = 1'b1;
                  kind_in      = KIND_READ;
                  state_in     = S_REPLY;
               end else begin
                  cmd.load_wr = 1'b1;
                  if (req_last) begin
                     cmd.rst_idx = 1'b1;
                     kind_in     = KIND_BUILD;
                     state_in    = S_CLEAR;
                  end
               end
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = kind_ff;
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clr_last) begin
               cmd.rst_idx = 1'b1;
               state_in    = S_LEAF;
            end
         end
         S_LEAF: begin
            cmd.op = OP_LEAF;
            if (stat.scan_done) begin
               cmd.rst_idx = 1'b1;
               if (stat.used_zero) begin
                  state_in = S_REPLY;
               end else if (stat.used_one) begin
                  state_in = S_WSYM;
               end else begin
                  cmd.rst_srch = 1'b1;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_done) begin
               cmd.rst_idx = 1'b1;
               state_in    = S_MERGE;
            end
         end
         S_MERGE: begin
            cmd.op = OP_MERGE;
            if (stat.step_done) begin
               cmd.rst_idx = 1'b1;
               if (stat.more_merge) begin
                  cmd.rst_srch = 1'b1;
                  state_in     = S_SCAN;
               end else begin
                  state_in = S_WSYM;
               end
            end
         end
         S_WSYM: begin
            cmd.op = OP_WSYM;
            if (stat.sym_end) begin
               cmd.rst_idx = 1'b1;
               if (stat.used_one) begin
                  state_in = S_REPLY;
               end else begin
                  cmd.rst_srch = 1'b1;
                  state_in     = S_FSCAN;
               end
            end else begin
               state_in = S_WLEAF;
            end
         end
         S_WLEAF: begin
            cmd.op   = OP_WLEAF;
            state_in = stat.leaf_valid ? S_WUP : S_WSYM;
         end
         S_WUP: begin
            cmd.op = OP_WUP;
            if (!stat.node_hp) begin
               state_in = S_WSYM;
            end
         end
         S_FSCAN: begin
            cmd.op = OP_FSCAN;
            if (stat.scan_done) begin
               cmd.rst_idx = 1'b1;
               state_in    = stat.hi_found ? S_FWR : S_REPLY;
            end
         end
         S_FWR: begin
            cmd.op = OP_FWR;
            if (stat.step_done) begin
               cmd.rst_idx  = 1'b1;
               cmd.rst_srch = 1'b1;
               state_in     = S_FSCAN;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         kind_ff  <= KIND_BUILD;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

@@ sv/hclb_dp.sv @@
module hclb_dp import hclb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [SYM_W-1:0]      req_symbol,
   input  logic [FREQ_W-1:0]     req_frequency,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [LEN_W-1:0]      rsp_code_length,
   output logic [CNT_W-1:0]      rsp_used_count
);

   // Storage.
   logic [FREQ_W-1:0]   freq_mem [MAX_SYMBOLS];
   logic [WEIGHT_W:0]   node_mem [NODE_SLOTS];   // {has parent, weight}
   logic [NODE_W-1:0]   par_mem  [NODE_SLOTS];
   logic [NODE_W:0]     leaf_mem [MAX_SYMBOLS];  // {valid, leaf node}
   logic [LEN_W-1:0]    len_mem  [MAX_SYMBOLS];

   logic [FREQ_W-1:0]   freq_rd_ff;
   logic [WEIGHT_W:0]   node_rd_ff;
   logic [NODE_W-1:0]   par_rd_ff;
   logic [NODE_W:0]     leaf_rd_ff;
   logic [LEN_W-1:0]    len_rd_ff;

   // Configuration.
   logic [CNT_W-1:0]    sym_count_ff;
   logic [LIM_W-1:0]    max_len_ff;

   // Sequencing and build state.
   logic [NODE_W-1:0]   idx_ff, idx_in;
   logic                dv_ff, dv_in;
   logic [NODE_W-1:0]   didx_ff;
   logic [NODE_W-1:0]   nodes_ff, nodes_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    live_ff, live_in;
   logic [CNT_W-1:0]    nonzero_ff, nonzero_in;
   logic [NODE_W-1:0]   depth_ff, depth_in;

   logic                a_v_ff, a_v_in, b_v_ff, b_v_in;
   logic [NODE_W-1:0]   a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [WEIGHT_W-1:0] a_w_ff, a_w_in, b_w_ff, b_w_in;

   logic                hi_v_ff, hi_v_in, lo_v_ff, lo_v_in;
   logic [SYM_W-1:0]    hi_idx_ff, hi_idx_in, lo_idx_ff, lo_idx_in;
   logic [LEN_W-1:0]    hi_len_ff, hi_len_in, lo_len_ff, lo_len_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [LEN_W-1:0]    rsp_len_ff;
   logic [CNT_W-1:0]    rsp_used_ff;

   // Memory ports.
   logic                freq_re;
   logic [SYM_W-1:0]    freq_raddr;
   logic                node_we, node_re;
   logic [NODE_W-1:0]   node_waddr, node_raddr;
   logic [WEIGHT_W:0]   node_wdata;
   logic                par_we;
   logic [NODE_W-1:0]   par_waddr;
   logic                leaf_we, leaf_re;
   logic [SYM_W-1:0]    leaf_waddr;
   logic [NODE_W:0]     leaf_wdata;
   logic                len_we, len_re;
   logic [SYM_W-1:0]    len_waddr, len_raddr;
   logic [LEN_W-1:0]    len_wdata;

   logic [CNT_W-1:0]    n_eff;
   logic [NODE_W-1:0]   scan_lim;
   logic                issue;
   logic                scanning;
   logic                scan_done;
   logic                freq_nz;
   logic [WEIGHT_W-1:0] cand_w;
   logic [LEN_W-1:0]    cand_len;
   logic [LEN_W-1:0]    limit;
   logic [LEN_W-1:0]    depth_len;
   logic [1:0]          step;

   always_comb begin
      n_eff     = (sym_count_ff > CNT_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : sym_count_ff;
      scan_lim  = (cmd.op == OP_SCAN) ? nodes_ff : NODE_W'(n_eff);
      issue     = (idx_ff != scan_lim);
      scanning  = (cmd.op == OP_LEAF) || (cmd.op == OP_SCAN) || (cmd.op == OP_FSCAN);
      scan_done = !issue && !dv_ff;
      freq_nz   = (freq_rd_ff != '0);
      cand_w    = node_rd_ff[WEIGHT_W-1:0];
      cand_len  = len_rd_ff;
      limit     = LEN_W'(max_len_ff);
      step      = idx_ff[1:0];
      if (depth_ff == '0) begin
         depth_len = LEN_W'(1);
      end else if (depth_ff > NODE_W'(LEN_CLAMP)) begin
         depth_len = LEN_CLAMP;
      end else begin
         depth_len = depth_ff[LEN_W-1:0];
      end
   end

   always_comb begin
      stat.clr_last   = (idx_ff[SYM_W-1:0] == '1);
      stat.scan_done  = scan_done;
      stat.used_zero  = (used_ff == '0);
      stat.used_one   = (used_ff == CNT_W'(1));
      stat.more_merge = (live_ff > CNT_W'(2));
      stat.step_done  = (cmd.op == OP_MERGE) ? (step == 2'd2) : (!lo_v_ff || idx_ff[0]);
      stat.sym_end    = (idx_ff == NODE_W'(n_eff));
      stat.leaf_valid = leaf_rd_ff[NODE_W];
      stat.node_hp    = node_rd_ff[WEIGHT_W];
      stat.hi_found   = hi_v_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection.
   always_comb begin
      freq_re    = (cmd.op == OP_LEAF) && issue;
      freq_raddr = idx_ff[SYM_W-1:0];

      node_we    = 1'b0;
      node_waddr = nodes_ff;
      node_wdata = {1'b0, {SYM_W{1'b0}}, freq_rd_ff};
      par_we     = 1'b0;
      par_waddr  = a_idx_ff;
      node_re    = 1'b0;
      node_raddr = idx_ff;

      leaf_we    = (cmd.op == OP_LEAF) && dv_ff;
      leaf_waddr = didx_ff[SYM_W-1:0];
      leaf_wdata = {freq_nz, nodes_ff};
      leaf_re    = (cmd.op == OP_WSYM) && !stat.sym_end;

      len_we     = 1'b0;
      len_waddr  = idx_ff[SYM_W-1:0];
      len_wdata  = '0;
      len_re     = cmd.rd_issue || ((cmd.op == OP_FSCAN) && issue);
      len_raddr  = cmd.rd_issue ? req_symbol : idx_ff[SYM_W-1:0];

      case (cmd.op)
         OP_CLEAR: begin
            len_we = 1'b1;
         end
         OP_LEAF: begin
            node_we = dv_ff && freq_nz;
         end
         OP_SCAN: begin
            node_re = issue;
         end
         OP_MERGE: begin
            node_we = 1'b1;
            case (step)
               2'd0: begin
                  node_wdata = {1'b0, a_w_ff + b_w_ff};
               end
               2'd1: begin
                  node_waddr = a_idx_ff;
                  node_wdata = {1'b1, a_w_ff};
                  par_we     = 1'b1;
               end
               default: begin
                  node_waddr = b_idx_ff;
                  node_wdata = {1'b1, b_w_ff};
                  par_we     = 1'b1;
                  par_waddr  = b_idx_ff;
               end
            endcase
         end
         OP_WLEAF: begin
            node_re    = leaf_rd_ff[NODE_W];
            node_raddr = leaf_rd_ff[NODE_W-1:0];
         end
         OP_WUP: begin
            node_re    = node_rd_ff[WEIGHT_W];
            node_raddr = par_rd_ff;
            len_we     = !node_rd_ff[WEIGHT_W];
            len_wdata  = depth_len;
         end
         OP_FWR: begin
            len_we = 1'b1;
            if (!idx_ff[0]) begin
               len_waddr = hi_idx_ff;
               len_wdata = lo_v_ff ? hi_len_ff - LEN_W'(1) : limit;
            end else begin
               len_waddr = lo_idx_ff;
               len_wdata = lo_len_ff + LEN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) freq_mem[req_symbol] <= req_frequency;
      if (freq_re) freq_rd_ff <= freq_mem[freq_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      if (node_re) node_rd_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (par_we) par_mem[par_waddr] <= nodes_ff;
      if (node_re) par_rd_ff <= par_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
      if (leaf_re) leaf_rd_ff <= leaf_mem[idx_ff[SYM_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      if (len_re) len_rd_ff <= len_mem[len_raddr];
   end

   // Counters and search registers.
   always_comb begin
      idx_in     = idx_ff;
      dv_in      = scanning && issue;
      nodes_in   = nodes_ff;
      used_in    = used_ff;
      live_in    = live_ff;
      nonzero_in = nonzero_ff;
      depth_in   = depth_ff;
      a_v_in     = a_v_ff;
      a_idx_in   = a_idx_ff;
      a_w_in     = a_w_ff;
      b_v_in     = b_v_ff;
      b_idx_in   = b_idx_ff;
      b_w_in     = b_w_ff;
      hi_v_in    = hi_v_ff;
      hi_idx_in  = hi_idx_ff;
      hi_len_in  = hi_len_ff;
      lo_v_in    = lo_v_ff;
      lo_idx_in  = lo_idx_ff;
      lo_len_in  = lo_len_ff;
      cnt_in     = cnt_ff;

      case (cmd.op)
         OP_CLEAR: begin
            idx_in     = idx_ff + NODE_W'(1);
            nodes_in   = '0;
            used_in    = '0;
            live_in    = '0;
            nonzero_in = '0;
         end
         OP_LEAF: begin
            if (issue) idx_in = idx_ff + NODE_W'(1);
            if (dv_ff && freq_nz) begin
               nodes_in   = nodes_ff + NODE_W'(1);
               used_in    = used_ff + CNT_W'(1);
               live_in    = live_ff + CNT_W'(1);
               nonzero_in = nonzero_ff + CNT_W'(1);
            end
         end
         OP_SCAN: begin
            if (issue) idx_in = idx_ff + NODE_W'(1);
            // Strictly lighter wins, so ties keep the lower node index.
            if (dv_ff && !node_rd_ff[WEIGHT_W]) begin
               if (!a_v_ff || cand_w < a_w_ff) begin
                  b_v_in   = a_v_ff;
                  b_idx_in = a_idx_ff;
                  b_w_in   = a_w_ff;
                  a_v_in   = 1'b1;
                  a_idx_in = didx_ff;
                  a_w_in   = cand_w;
               end else if (!b_v_ff || cand_w < b_w_ff) begin
                  b_v_in   = 1'b1;
                  b_idx_in = didx_ff;
                  b_w_in   = cand_w;
               end
            end
         end
         OP_MERGE: begin
            idx_in = idx_ff + NODE_W'(1);
            if (step == 2'd2) begin
               nodes_in = nodes_ff + NODE_W'(1);
               live_in  = live_ff - CNT_W'(1);
            end
         end
         OP_WSYM: begin
            depth_in = '0;
         end
         OP_WLEAF: begin
            if (!leaf_rd_ff[NODE_W]) idx_in = idx_ff + NODE_W'(1);
         end
         OP_WUP: begin
            if (node_rd_ff[WEIGHT_W]) begin
               depth_in = depth_ff + NODE_W'(1);
            end else begin
               idx_in = idx_ff + NODE_W'(1);
            end
         end
         OP_FSCAN: begin
            if (issue) idx_in = idx_ff + NODE_W'(1);
            if (dv_ff) begin
               if (cand_len > limit && (!hi_v_ff || cand_len > hi_len_ff)) begin
                  hi_v_in   = 1'b1;
                  hi_idx_in = didx_ff[SYM_W-1:0];
                  hi_len_in = cand_len;
               end
               if (cand_len != '0 && cand_len < limit &&
                   (!lo_v_ff || cand_len < lo_len_ff)) begin
                  lo_v_in   = 1'b1;
                  lo_idx_in = didx_ff[SYM_W-1:0];
                  lo_len_in = cand_len;
               end
               if (cand_len != '0) cnt_in = cnt_ff + CNT_W'(1);
            end
            // A final pass with nothing over the limit gives the used count.
            if (scan_done && !hi_v_ff) nonzero_in = cnt_ff;
         end
         OP_FWR: begin
            idx_in = idx_ff + NODE_W'(1);
         end
         default: begin
         end
      endcase

      if (cmd.rst_idx) begin
         idx_in = '0;
         dv_in  = 1'b0;
      end
      if (cmd.rst_srch) begin
         a_v_in  = 1'b0;
         b_v_in  = 1'b0;
         hi_v_in = 1'b0;
         lo_v_in = 1'b0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         dv_ff      <= 1'b0;
         nodes_ff   <= '0;
         used_ff    <= '0;
         live_ff    <= '0;
         nonzero_ff <= '0;
         a_v_ff     <= 1'b0;
         b_v_ff     <= 1'b0;
         hi_v_ff    <= 1'b0;
         lo_v_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         idx_ff     <= idx_in;
         dv_ff      <= dv_in;
         nodes_ff   <= nodes_in;
         used_ff    <= used_in;
         live_ff    <= live_in;
         nonzero_ff <= nonzero_in;
         a_v_ff     <= a_v_in;
         b_v_ff     <= b_v_in;
         hi_v_ff    <= hi_v_in;
         lo_v_ff    <= lo_v_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff   <= idx_ff;
      depth_ff  <= depth_in;
      a_idx_ff  <= a_idx_in;
      a_w_ff    <= a_w_in;
      b_idx_ff  <= b_idx_in;
      b_w_ff    <= b_w_in;
      hi_idx_ff <= hi_idx_in;
      hi_len_ff <= hi_len_in;
      lo_idx_ff <= lo_idx_in;
      lo_len_ff <= lo_len_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_count_ff <= SYMBOL_COUNT_RESET;
         max_len_ff   <= MAX_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYMBOL_COUNT:    sym_count_ff <= csr_wdata;
            CSR_MAX_CODE_LENGTH: max_len_ff   <= csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_kind_ff <= cmd.out_kind;
         rsp_len_ff  <= (cmd.out_kind == KIND_READ) ? len_rd_ff : '0;
         rsp_used_ff <= nonzero_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_code_length = rsp_len_ff;
   assign rsp_used_count  = rsp_used_ff;

endmodule
